// ===== hw/rtl/srtsg_pkg.sv =====
// ----------------------------------------------------------------------------
// srtsg_pkg
// Shared types and constants for the scrub region table span generator.
// ----------------------------------------------------------------------------
package srtsg_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int PAGE_W      = 24;
  localparam int SIZE_W      = PAGE_W + 1;
  localparam int SPAN_W      = 24;
  localparam int PERIOD_W    = 32;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int DIV_STEPS   = PERIOD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [SIZE_W-1:0]   PAGE_LIMIT     = SIZE_W'(1) << PAGE_W;
  localparam logic [SPAN_W-1:0]   SPAN_RESET     = SPAN_W'((8 * 1024 * 1024) / 4096);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(12 * 60 * 60);
  localparam logic [CNT_W-1:0]    TABLE_FULL_CNT = CNT_W'(MAX_REGIONS);

  // operation codes
  typedef enum logic [1:0] {
    FN_ADD  = 2'd0,
    FN_DEL  = 2'd1,
    FN_NEXT = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLASH = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(1);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_SCAN,
    S_ADD_NEXT,
    S_DEL_SCAN,
    S_NXT_SCAN,
    S_NXT_WRAP,
    S_DIV_Q,
    S_DIV_I,
    S_SHIFT_UP,
    S_SHIFT_DOWN
  } state_t;

  // divider handshake
  typedef struct packed {
    logic                start;
    logic [PERIOD_W-1:0] dividend;
    logic [SIZE_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/srtsg_div.sv =====
// ----------------------------------------------------------------------------
// srtsg_div
// Restoring divider, one quotient bit per cycle, done pulse after the last.
// ----------------------------------------------------------------------------
module srtsg_div import srtsg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [PERIOD_W-1:0]  quo_r, quo_nxt;
  logic [SIZE_W-1:0]    dvs_r, dvs_nxt;
  logic [SIZE_W:0]      trial;
  logic                 ge;

  // one shift and subtract step
  assign trial = {rem_r, quo_r[PERIOD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      rem_nxt = ge ? SIZE_W'(trial - {1'b0, dvs_r}) : trial[SIZE_W-1:0];
      quo_nxt = {quo_r[PERIOD_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== hw/rtl/scrub_region_table_span_generator_core.sv =====
// ----------------------------------------------------------------------------
// scrub_region_table_span_generator_core
// Sorted table of scrub page ranges with add, delete and next-span commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Busy then stays high
// until its single result is shown on the out_ ports for one cycle, marked by
// out_valid, which the receiver must take as it comes. The table is walked
// one entry a cycle through a single read port, and inserts and removals move
// entries one a cycle. A next-span request walks the table and, when the total
// exceeds a nonzero span, runs the divider twice: once for the number of spans
// in the table and once for the period over that number. Configuration writes
// are always taken and should only be made while busy is low.
module scrub_region_table_span_generator_core import srtsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // command transfer
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_func,
  input  logic [PAGE_W-1:0]     in_page_number,
  input  logic [PAGE_W-1:0]     in_page_count,
  // result transfer
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [PAGE_W-1:0]     out_span_start,
  output logic [SPAN_W-1:0]     out_span_page_count,
  output logic                  out_list_end,
  output logic [PERIOD_W-1:0]   out_interval_seconds,
  // configuration transfer
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [SPAN_W-1:0]   span_r;
  logic [PERIOD_W-1:0] period_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SIZE_W-1:0]   total_r, total_nxt;
  logic [SIZE_W-1:0]   cursor_r, cursor_nxt;

  logic [1:0]          func_r, func_nxt;
  logic [PAGE_W-1:0]   p_r, p_nxt;
  logic [PAGE_W-1:0]   n_r, n_nxt;
  logic [SIZE_W-1:0]   pend_r, pend_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [CNT_W-1:0]    ins_r, ins_nxt;
  logic [PAGE_W-1:0]   ins_start_r, ins_start_nxt;
  logic [SIZE_W-1:0]   ins_size_r, ins_size_nxt;
  logic [PAGE_W-1:0]   cur_start_r, cur_start_nxt;
  logic [SIZE_W-1:0]   cur_size_r, cur_size_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [PAGE_W-1:0]   res_start_r, res_start_nxt;
  logic [SPAN_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic                res_fin_r, res_fin_nxt;
  logic [PERIOD_W-1:0] res_ival_r, res_ival_nxt;

  // region table storage
  logic [PAGE_W-1:0]   tbl_start_r [MAX_REGIONS];
  logic [SIZE_W-1:0]   tbl_size_r  [MAX_REGIONS];
  logic                tbl_we;
  logic [IDX_W-1:0]    tbl_waddr;
  logic [PAGE_W-1:0]   tbl_wstart;
  logic [SIZE_W-1:0]   tbl_wsize;
  logic [CNT_W-1:0]    rsel;
  logic [IDX_W-1:0]    raddr;
  logic [PAGE_W-1:0]   rd_start;
  logic [SIZE_W-1:0]   rd_size;
  logic [SIZE_W-1:0]   rd_end;

  // span clip terms
  logic [SIZE_W-1:0]   cval;
  logic [CNT_W-1:0]    fin_idx;
  logic [SIZE_W-1:0]   rem;
  logic [SPAN_W-1:0]   clip_cnt;
  logic [SIZE_W-1:0]   clip_stop;

  div_req_t div_req;
  div_rsp_t div_rsp;

  srtsg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // single read port of the table
  always_comb begin
    unique case (state_r)
      S_ADD_NEXT:   rsel = idx_r + CNT_W'(1);
      S_SHIFT_DOWN: rsel = j_r + CNT_W'(1);
      S_SHIFT_UP:   rsel = j_r - CNT_W'(1);
      S_NXT_WRAP:   rsel = '0;
      default:      rsel = idx_r;
    endcase
  end

  assign raddr    = rsel[IDX_W-1:0];
  assign rd_start = tbl_start_r[raddr];
  assign rd_size  = tbl_size_r[raddr];
  assign rd_end   = {1'b0, rd_start} + rd_size;

  // clip the span to the end of the selected range
  always_comb begin
    if (state_r == S_NXT_WRAP) begin
      cval    = {1'b0, rd_start};
      fin_idx = '0;
    end else begin
      cval    = (cursor_r < {1'b0, rd_start}) ? {1'b0, rd_start} : cursor_r;
      fin_idx = idx_r;
    end
    rem       = rd_end - cval;
    clip_cnt  = ({1'b0, span_r} < rem) ? span_r : rem[SPAN_W-1:0];
    clip_stop = cval + {1'b0, clip_cnt};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    cursor_nxt    = cursor_r;
    func_nxt      = func_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    ins_nxt       = ins_r;
    ins_start_nxt = ins_start_r;
    ins_size_nxt  = ins_size_r;
    cur_start_nxt = cur_start_r;
    cur_size_nxt  = cur_size_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    res_start_nxt = res_start_r;
    res_cnt_nxt   = res_cnt_r;
    res_fin_nxt   = res_fin_r;
    res_ival_nxt  = res_ival_r;
    tbl_we        = 1'b0;
    tbl_waddr     = raddr;
    tbl_wstart    = rd_start;
    tbl_wsize     = rd_size;
    div_req.start    = 1'b0;
    div_req.dividend = {{(PERIOD_W-SIZE_W){1'b0}}, total_r};
    div_req.divisor  = {1'b0, span_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          p_nxt     = in_page_number;
          n_nxt     = in_page_count;
          pend_nxt  = {1'b0, in_page_number} + {1'b0, in_page_count};
          idx_nxt   = '0;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt    = ST_OK;
        res_start_nxt = '0;
        res_cnt_nxt   = '0;
        res_fin_nxt   = 1'b0;
        res_ival_nxt  = '0;
        unique case (func_t'(func_r))
          FN_ADD: begin
            if (n_r == '0) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else if (pend_r > PAGE_LIMIT) begin
              status_nxt    = ST_CLASH;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_ADD_SCAN;
            end
          end
          FN_DEL:  state_nxt = S_DEL_SCAN;
          FN_NEXT: begin
            if (count_r == '0) begin
              status_nxt    = ST_EMPTY;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_NXT_SCAN;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      // find the first range whose end is not below the new start
      S_ADD_SCAN: begin
        if (idx_r == count_r) begin
          if (count_r == TABLE_FULL_CNT) begin
            status_nxt    = ST_FULL;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            ins_nxt       = idx_r;
            ins_start_nxt = p_r;
            ins_size_nxt  = {1'b0, n_r};
            j_nxt         = count_r;
            total_nxt     = total_r + {1'b0, n_r};
            state_nxt     = S_SHIFT_UP;
          end
        end else if ({1'b0, p_r} > rd_end) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else if (pend_r == {1'b0, rd_start}) begin
          tbl_we        = 1'b1;
          tbl_wstart    = p_r;
          tbl_wsize     = rd_size + {1'b0, n_r};
          total_nxt     = total_r + {1'b0, n_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if ({1'b0, p_r} == rd_end) begin
          cur_start_nxt = rd_start;
          cur_size_nxt  = rd_size;
          state_nxt     = S_ADD_NEXT;
        end else if (pend_r > {1'b0, rd_start}) begin
          status_nxt    = ST_CLASH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (count_r == TABLE_FULL_CNT) begin
          status_nxt    = ST_FULL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ins_nxt       = idx_r;
          ins_start_nxt = p_r;
          ins_size_nxt  = {1'b0, n_r};
          j_nxt         = count_r;
          total_nxt     = total_r + {1'b0, n_r};
          state_nxt     = S_SHIFT_UP;
        end
      end

      // append to a range, checking and maybe joining the following one
      S_ADD_NEXT: begin
        tbl_waddr  = idx_r[IDX_W-1:0];
        tbl_wstart = cur_start_r;
        tbl_wsize  = cur_size_r + {1'b0, n_r};
        if (idx_r + CNT_W'(1) < count_r && pend_r > {1'b0, rd_start}) begin
          status_nxt    = ST_CLASH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (idx_r + CNT_W'(1) < count_r && pend_r == {1'b0, rd_start}) begin
          tbl_we    = 1'b1;
          tbl_wsize = cur_size_r + {1'b0, n_r} + rd_size;
          total_nxt = total_r + {1'b0, n_r};
          j_nxt     = idx_r + CNT_W'(1);
          state_nxt = S_SHIFT_DOWN;
        end else begin
          tbl_we        = 1'b1;
          total_nxt     = total_r + {1'b0, n_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // find the range holding the first page, then trim, drop or split
      S_DEL_SCAN: begin
        if (idx_r == count_r) begin
          status_nxt    = ST_CLASH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (p_r >= rd_start && {1'b0, p_r} < rd_end) begin
          if (pend_r > rd_end) begin
            status_nxt    = ST_CLASH;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (n_r == '0) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (p_r == rd_start) begin
            total_nxt = total_r - {1'b0, n_r};
            if ({1'b0, n_r} == rd_size) begin
              j_nxt     = idx_r;
              state_nxt = S_SHIFT_DOWN;
            end else begin
              tbl_we        = 1'b1;
              tbl_wstart    = rd_start + n_r;
              tbl_wsize     = rd_size - {1'b0, n_r};
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end else if (pend_r == rd_end) begin
            tbl_we        = 1'b1;
            tbl_wsize     = rd_size - {1'b0, n_r};
            total_nxt     = total_r - {1'b0, n_r};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (count_r == TABLE_FULL_CNT) begin
            status_nxt    = ST_FULL;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            tbl_we        = 1'b1;
            tbl_wsize     = {1'b0, p_r - rd_start};
            total_nxt     = total_r - {1'b0, n_r};
            ins_nxt       = idx_r + CNT_W'(1);
            ins_start_nxt = pend_r[PAGE_W-1:0];
            ins_size_nxt  = rd_end - pend_r;
            j_nxt         = count_r;
            state_nxt     = S_SHIFT_UP;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      // find the range at or after the cursor, wrap to the first one
      S_NXT_SCAN, S_NXT_WRAP: begin
        if (state_r == S_NXT_SCAN && idx_r == count_r) begin
          state_nxt = S_NXT_WRAP;
        end else if (state_r == S_NXT_SCAN && cursor_r >= rd_end) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          res_start_nxt = cval[PAGE_W-1:0];
          res_cnt_nxt   = clip_cnt;
          res_fin_nxt   = (fin_idx + CNT_W'(1) == count_r) && (clip_stop == rd_end);
          cursor_nxt    = clip_stop;
          if (total_r <= {1'b0, span_r} || span_r == '0) begin
            res_ival_nxt  = period_r;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV_Q;
          end
        end
      end

      // spans in the table, then period over spans
      S_DIV_Q: begin
        div_req.dividend = period_r;
        div_req.divisor  = div_rsp.quotient[SIZE_W-1:0];
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV_I;
        end
      end

      S_DIV_I: begin
        if (div_rsp.done) begin
          res_ival_nxt  = div_rsp.quotient;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // open a gap at the insert slot, one entry a cycle from the top
      S_SHIFT_UP: begin
        tbl_we    = 1'b1;
        tbl_waddr = j_r[IDX_W-1:0];
        if (j_r > ins_r) begin
          j_nxt = j_r - CNT_W'(1);
        end else begin
          tbl_wstart    = ins_start_r;
          tbl_wsize     = ins_size_r;
          count_nxt     = count_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // close the gap of a removed entry, one entry a cycle
      S_SHIFT_DOWN: begin
        tbl_waddr = j_r[IDX_W-1:0];
        if (j_r + CNT_W'(1) < count_r) begin
          tbl_we = 1'b1;
          j_nxt  = j_r + CNT_W'(1);
        end else begin
          count_nxt     = count_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    p_r         <= p_nxt;
    n_r         <= n_nxt;
    pend_r      <= pend_nxt;
    idx_r       <= idx_nxt;
    j_r         <= j_nxt;
    ins_r       <= ins_nxt;
    ins_start_r <= ins_start_nxt;
    ins_size_r  <= ins_size_nxt;
    cur_start_r <= cur_start_nxt;
    cur_size_r  <= cur_size_nxt;
    status_r    <= status_nxt;
    res_start_r <= res_start_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_fin_r   <= res_fin_nxt;
    res_ival_r  <= res_ival_nxt;
  end

  // table write port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_start_r[tbl_waddr] <= tbl_wstart;
      tbl_size_r[tbl_waddr]  <= tbl_wsize;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r   <= SPAN_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SPAN) begin
        span_r <= cfg_data[SPAN_W-1:0];
      end else if (cfg_index == CFG_PERIOD) begin
        period_r <= cfg_data[PERIOD_W-1:0];
      end
    end
  end

  assign cfg_ready            = 1'b1;
  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_span_start       = res_start_r;
  assign out_span_page_count  = res_cnt_r;
  assign out_list_end         = res_fin_r;
  assign out_interval_seconds = res_ival_r;

endmodule

// ===== tb/sv/scrub_region_table_span_generator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scrub_region_table_span_generator_core_tb
// Self-checking bench for the scrub region table and span generator. A
// scoreboard class tracks the range table, page total and scrub cursor,
// works out the expected result of every accepted command and checks each
// result strobe against it. Stimulus is a directed opening followed by
// mostly well-formed add, delete and next-span traffic over several
// configuration settings, with bursty command timing.
// ----------------------------------------------------------------------------
module scrub_region_table_span_generator_core_tb;
  import srtsg_pkg::*;

  localparam int          STALL_LIMIT = 5000;
  localparam int          SETTLE_CYC  = 200;
  localparam longint unsigned PAGE_SPACE = 64'd1 << PAGE_W;

  typedef struct {
    status_t                    status;
    logic [PAGE_W-1:0]          span_start;
    logic [SPAN_W-1:0]          span_pages;
    logic                       at_end;
    logic [PERIOD_W-1:0]        interval;
  } span_result_t;

  // table tracker and result checker
  class scrub_table_scoreboard;
    longint unsigned rng_start[MAX_REGIONS];
    longint unsigned rng_size[MAX_REGIONS];
    int              rng_cnt;
    longint unsigned cursor;
    longint unsigned total;
    longint unsigned span_cfg;
    longint unsigned period_cfg;
    span_result_t    awaited[$];
    int              errors;

    function new();
      rng_cnt    = 0;
      cursor     = 0;
      total      = 0;
      span_cfg   = SPAN_RESET;
      period_cfg = PERIOD_RESET;
      errors     = 0;
    endfunction

    function void remove_at(int i);
      for (int j = i; j + 1 < rng_cnt; j++) begin
        rng_start[j] = rng_start[j+1];
        rng_size[j]  = rng_size[j+1];
      end
      rng_cnt--;
    endfunction

    function void insert_at(int i, longint unsigned s, longint unsigned n);
      for (int j = rng_cnt; j > i; j--) begin
        rng_start[j] = rng_start[j-1];
        rng_size[j]  = rng_size[j-1];
      end
      rng_start[i] = s;
      rng_size[i]  = n;
      rng_cnt++;
    endfunction

    function status_t add_pages(longint unsigned p, longint unsigned n);
      longint unsigned e;
      int i;
      e = p + n;
      i = 0;
      if (n == 0) return ST_OK;
      if (e > PAGE_SPACE) return ST_CLASH;
      while (i < rng_cnt && p > rng_start[i] + rng_size[i]) i++;
      if (i == rng_cnt) begin
        if (rng_cnt >= MAX_REGIONS) return ST_FULL;
        insert_at(i, p, n);
      end else if (e == rng_start[i]) begin
        rng_start[i] = p;
        rng_size[i] += n;
      end else if (p == rng_start[i] + rng_size[i]) begin
        if (i + 1 < rng_cnt) begin
          if (e > rng_start[i+1]) return ST_CLASH;
          // new range bridges the gap to the next entry
          if (e == rng_start[i+1]) begin
            rng_size[i] += n + rng_size[i+1];
            remove_at(i + 1);
            total += n;
            return ST_OK;
          end
        end
        rng_size[i] += n;
      end else begin
        if (e > rng_start[i]) return ST_CLASH;
        if (rng_cnt >= MAX_REGIONS) return ST_FULL;
        insert_at(i, p, n);
      end
      total += n;
      return ST_OK;
    endfunction

    function status_t del_pages(longint unsigned p, longint unsigned n);
      longint unsigned e;
      int i;
      for (i = 0; i < rng_cnt; i++)
        if (p >= rng_start[i] && p < rng_start[i] + rng_size[i]) break;
      if (i == rng_cnt) return ST_CLASH;
      e = rng_start[i] + rng_size[i];
      if (p + n > e) return ST_CLASH;
      if (n == 0) return ST_OK;
      if (p == rng_start[i]) begin
        if (n == rng_size[i]) remove_at(i);
        else begin
          rng_start[i] += n;
          rng_size[i]  -= n;
        end
      end else if (p + n == e) begin
        rng_size[i] -= n;
      end else begin
        // split leaves a hole in the middle
        if (rng_cnt >= MAX_REGIONS) return ST_FULL;
        insert_at(i + 1, p + n, e - (p + n));
        rng_size[i] = p - rng_start[i];
      end
      total -= n;
      return ST_OK;
    endfunction

    function void note_command(func_t f, longint unsigned p, longint unsigned n);
      span_result_t r;
      longint unsigned c, e, cnt;
      int i;
      bit hit;
      r = '{ST_OK, '0, '0, 1'b0, '0};
      case (f)
        FN_ADD: r.status = add_pages(p, n);
        FN_DEL: r.status = del_pages(p, n);
        FN_NEXT: begin
          if (rng_cnt == 0) r.status = ST_EMPTY;
          else begin
            if (total <= span_cfg || span_cfg == 0) r.interval = PERIOD_W'(period_cfg);
            else r.interval = PERIOD_W'(period_cfg / (total / span_cfg));
            c   = cursor;
            hit = 0;
            for (i = 0; i < rng_cnt; i++) begin
              if (c < rng_start[i]) begin
                c   = rng_start[i];
                hit = 1;
                break;
              end
              if (c < rng_start[i] + rng_size[i]) begin
                hit = 1;
                break;
              end
            end
            // wrap to the first range
            if (!hit) begin
              i = 0;
              c = rng_start[0];
            end
            e   = rng_start[i] + rng_size[i];
            cnt = (span_cfg < e - c) ? span_cfg : e - c;
            r.at_end     = (i + 1 == rng_cnt && c + cnt == e);
            r.span_start = c[PAGE_W-1:0];
            r.span_pages = cnt[SPAN_W-1:0];
            cursor       = c + cnt;
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [PAGE_W-1:0] ss,
                               logic [SPAN_W-1:0] sp, logic fin,
                               logic [PERIOD_W-1:0] iv);
      span_result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status=%0d start=%0h", $time, st, ss);
        errors++;
        return;
      end
      r = awaited.pop_front();
      if (st !== r.status) begin
        $display("%0t: status exp %0d got %0d", $time, r.status, st);
        errors++;
      end
      if (ss !== r.span_start) begin
        $display("%0t: span_start exp %0h got %0h", $time, r.span_start, ss);
        errors++;
      end
      if (sp !== r.span_pages) begin
        $display("%0t: span_page_count exp %0h got %0h", $time, r.span_pages, sp);
        errors++;
      end
      if (fin !== r.at_end) begin
        $display("%0t: list_end exp %0b got %0b", $time, r.at_end, fin);
        errors++;
      end
      if (iv !== r.interval) begin
        $display("%0t: interval_seconds exp %0d got %0d", $time, r.interval, iv);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_func;
  logic [PAGE_W-1:0]     in_page_number;
  logic [PAGE_W-1:0]     in_page_count;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [PAGE_W-1:0]     out_span_start;
  logic [SPAN_W-1:0]     out_span_page_count;
  logic                  out_list_end;
  logic [PERIOD_W-1:0]   out_interval_seconds;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scrub_table_scoreboard sb;
  int                    idle_cycles;

  scrub_region_table_span_generator_core uut (.*);

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_status, out_span_start, out_span_page_count,
                        out_list_end, out_interval_seconds);
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // one command transfer; start is left high for a following command
  task automatic send_cmd(func_t f, logic [PAGE_W-1:0] p, logic [PAGE_W-1:0] n);
    start          <= 1'b1;
    in_func        <= f;
    in_page_number <= p;
    in_page_count  <= n;
    do @(posedge clk); while (busy);
    sb.note_command(f, p, n);
  endtask

  task automatic pause_cmds(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait for every outstanding result, then let the block settle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SPAN) sb.span_cfg = val[SPAN_W-1:0];
    else sb.period_cfg = val;
    @(posedge clk);
  endtask

  function automatic logic [PAGE_W-1:0] small_len();
    return PAGE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 20000)
                                               : $urandom_range(1, 300));
  endfunction

  // mostly well-formed commands built around the current table
  task automatic random_cmd();
    int              k, i;
    longint unsigned s, z, p, n;
    k = $urandom_range(0, 99);
    i = (sb.rng_cnt > 0) ? $urandom_range(0, sb.rng_cnt - 1) : 0;
    s = sb.rng_start[i];
    z = sb.rng_size[i];
    if (sb.rng_cnt >= 13 && k < 40) k = k + 40;
    if (k < 40) begin
      n = small_len();
      case ($urandom_range(0, 5))
        0: p = (sb.rng_cnt > 0) ? s + z : $urandom_range(0, 4000);
        1: p = (sb.rng_cnt > 0 && s >= n) ? s - n : 0;
        2: p = (sb.rng_cnt > 0) ? s + z + $urandom_range(1, 600) : $urandom_range(0, 4000);
        3: p = (sb.rng_cnt > 0 && i + 1 < sb.rng_cnt) ? s + z : $urandom_range(0, 9000);
        4: p = $urandom_range(0, 9000);
        default: begin
          p = $urandom & 24'hFFFFFF;
          n = $urandom & 24'hFFFFFF;
        end
      endcase
      if (k % 7 == 0 && sb.rng_cnt > 0 && i + 1 < sb.rng_cnt) begin
        // bridge exactly to the next range
        p = s + z;
        n = sb.rng_start[i+1] - p;
      end
      send_cmd(FN_ADD, p[PAGE_W-1:0], n[PAGE_W-1:0]);
    end else if (k < 65) begin
      if (sb.rng_cnt == 0 || $urandom_range(0, 9) == 0) begin
        p = $urandom & 24'hFFFFFF;
        n = $urandom_range(0, 1) ? ($urandom & 24'hFFFFFF) : $urandom_range(0, 50);
      end else begin
        p = s + $urandom_range(0, int'(z - 1));
        case ($urandom_range(0, 3))
          0: n = s + z - p;
          1: n = s + z - p + $urandom_range(1, 5);
          default: n = $urandom_range(0, int'(s + z - p));
        endcase
      end
      send_cmd(FN_DEL, p[PAGE_W-1:0], n[PAGE_W-1:0]);
    end else if (k < 96) begin
      send_cmd(FN_NEXT, PAGE_W'($urandom), PAGE_W'($urandom));
    end else begin
      send_cmd(FN_NONE, PAGE_W'($urandom), PAGE_W'($urandom));
    end
  endtask

  task automatic random_phase(int items);
    int left, burst;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && left > 0; b++) begin
        random_cmd();
        left--;
      end
      if ($urandom_range(0, 3) != 0) pause_cmds($urandom_range(1, 40));
    end
  endtask

  logic [SPAN_W-1:0]   span_set[6]   = '{24'd1, 24'hFFFFFF, 24'd0, 24'd7, 24'd64, 24'd2048};
  logic [PERIOD_W-1:0] period_set[6] = '{32'hFFFFFFFF, 32'd1, 32'd500, 32'd43200,
                                         32'd100000, 32'd43200};

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_func        = FN_ADD;
    in_page_number = '0;
    in_page_count  = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_SPAN;
    cfg_data       = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, edge ranges and every operation
    send_cmd(FN_NEXT, 24'd0, 24'd0);
    send_cmd(FN_DEL, 24'd10, 24'd1);
    send_cmd(FN_ADD, 24'd100, 24'd0);
    send_cmd(FN_ADD, 24'hFFFFFF, 24'd2);
    send_cmd(FN_ADD, 24'hFFFFF0, 24'd16);
    send_cmd(FN_ADD, 24'd0, 24'hFFFFFF);
    send_cmd(FN_ADD, 24'd5000, 24'd1000);
    send_cmd(FN_ADD, 24'd4990, 24'd20);
    send_cmd(FN_ADD, 24'd4000, 24'd1000);
    send_cmd(FN_ADD, 24'd8000, 24'd100);
    send_cmd(FN_ADD, 24'd6000, 24'd2000);
    send_cmd(FN_DEL, 24'd4100, 24'd0);
    send_cmd(FN_DEL, 24'd4100, 24'd200);
    send_cmd(FN_DEL, 24'd4300, 24'd99999);
    send_cmd(FN_DEL, 24'd3000, 24'd1);
    send_cmd(FN_NONE, 24'hFFFFFF, 24'hFFFFFF);
    for (int j = 0; j < 6; j++) send_cmd(FN_NEXT, 24'd0, 24'd0);
    // fill the table, then try a new entry and a split
    for (int j = 0; j < 14; j++) send_cmd(FN_ADD, 24'(20000 + 100 * j), 24'd10);
    send_cmd(FN_ADD, 24'd50000, 24'd5);
    send_cmd(FN_DEL, 24'd20002, 24'd3);
    send_cmd(FN_DEL, 24'hFFFFF0, 24'd16);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SPAN, 32'(span_set[ph]));
      write_reg(CFG_PERIOD, period_set[ph]);
      random_phase(ph == 5 ? 100 : 300);
      drain();
    end

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
